@@ design/byte_signature_hamming_scan_defines.svh @@
// assertion macros for the byte signature scanner
`ifndef BYTE_SIGNATURE_HAMMING_SCAN_DEFINES_SVH
`define BYTE_SIGNATURE_HAMMING_SCAN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BSHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bshs_pkg.sv @@
// shared constants, types and signature tables of the byte signature scanner
`default_nettype none

package bshs_pkg;

    localparam int NUM_SIG     = 4;
    localparam int WINDOW_LEN  = 36;
    localparam int CELL_IDX_W  = $clog2(WINDOW_LEN);
    localparam int OFFSET_BITS = 32;
    localparam int MATCH_W     = 32;
    localparam int VERDICT_W   = 3;
    localparam int CNT_W       = 6;
    localparam int THR_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int BYTE_W      = 8;
    localparam int FLUSH_LEN   = 15;
    localparam int FLUSH_CNT_W = $clog2(FLUSH_LEN + 1);
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - MATCH_W - VERDICT_W;

    localparam logic [VERDICT_W-1:0] VERDICT_CLEAN = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_THREE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 2'd3;

    localparam logic [1:0] SIG_ONE   = 2'd0;
    localparam logic [1:0] SIG_TWO   = 2'd1;
    localparam logic [1:0] SIG_THREE = 2'd2;
    localparam logic [1:0] SIG_FOUR  = 2'd3;

    localparam logic [THR_W-1:0] THR_ONE_RST   = 6'd20;
    localparam logic [THR_W-1:0] THR_TWO_RST   = 6'd27;
    localparam logic [THR_W-1:0] THR_THREE_RST = 6'd31;
    localparam logic [THR_W-1:0] THR_FOUR_RST  = 6'd31;

    localparam int PAT_LEN_ONE   = 25;
    localparam int PAT_LEN_TWO   = 32;
    localparam int PAT_LEN_THREE = 36;
    localparam int PAT_LEN_FOUR  = 36;

    typedef logic [CNT_W-1:0] count_t;
    typedef count_t [NUM_SIG-1:0] counts_t;
    typedef logic [NUM_SIG-1:0][BYTE_W-1:0] sig_bytes_t;
    typedef logic [THR_W-1:0] thr_t;

    // signatures padded to the window length, padding is masked by length
    localparam logic [0:WINDOW_LEN-1][BYTE_W-1:0] PAT_ONE = {
        8'hAB, 8'h8B, 8'hC6, 8'hAB, 8'h64, 8'h89, 8'h23, 8'h60, 8'h87, 8'h43,
        8'hFE, 8'h83, 8'hEF, 8'h97, 8'h58, 8'h57, 8'h57, 8'hAC, 8'hD2, 8'hC0,
        8'h34, 8'h4B, 8'h57, 8'h92, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00 };
    localparam logic [0:WINDOW_LEN-1][BYTE_W-1:0] PAT_TWO = {
        8'h33, 8'h19, 8'h75, 8'h08, 8'h8B, 8'h44, 8'h24, 8'h28, 8'hAA, 8'h47,
        8'hEB, 8'h0A, 8'h3C, 8'h77, 8'h75, 8'h1B, 8'h47, 8'h8B, 8'h44, 8'h24,
        8'h28, 8'hAA, 8'hE8, 8'h08, 8'h00, 8'h00, 8'h00, 8'h53, 8'h6B, 8'h61,
        8'h2E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00 };
    localparam logic [0:WINDOW_LEN-1][BYTE_W-1:0] PAT_THREE = {
        8'h58, 8'hFF, 8'hE0, 8'h8B, 8'h85, 8'h57, 8'h17, 8'h40, 8'h00, 8'h50,
        8'hB9, 8'h78, 8'h56, 8'h34, 8'h12, 8'hFF, 8'h95, 8'hE6, 8'h16, 8'h40,
        8'h00, 8'h89, 8'h85, 8'h53, 8'h17, 8'h40, 8'h00, 8'h83, 8'hF8, 8'hFF,
        8'h75, 8'h01, 8'hC3, 8'h6A, 8'h20, 8'h8B };
    localparam logic [0:WINDOW_LEN-1][BYTE_W-1:0] PAT_FOUR = {
        8'h2B, 8'hFF, 8'hBF, 8'h00, 8'h10, 8'h00, 8'hC0, 8'hB8, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'hB9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF2, 8'hAE, 8'h8B,
        8'hD9, 8'h0B, 8'hC9, 8'h0F, 8'h84, 8'h80, 8'h00, 8'h00, 8'h00, 8'h81,
        8'hFF, 8'h00, 8'hC0, 8'h00, 8'hC0, 8'h73 };

    // expected bytes of all signatures at one window position
    function automatic sig_bytes_t cell_bytes(input logic [CELL_IDX_W-1:0] pos);
        sig_bytes_t b;
        b[SIG_ONE]   = PAT_ONE[pos];
        b[SIG_TWO]   = PAT_TWO[pos];
        b[SIG_THREE] = PAT_THREE[pos];
        b[SIG_FOUR]  = PAT_FOUR[pos];
        return b;
    endfunction

    // which signatures extend over a window position
    function automatic logic [NUM_SIG-1:0] cell_used(input logic [CELL_IDX_W-1:0] pos);
        logic [NUM_SIG-1:0] u;
        u[SIG_ONE]   = (int'(pos) < PAT_LEN_ONE);
        u[SIG_TWO]   = (int'(pos) < PAT_LEN_TWO);
        u[SIG_THREE] = (int'(pos) < PAT_LEN_THREE);
        u[SIG_FOUR]  = (int'(pos) < PAT_LEN_FOUR);
        return u;
    endfunction

endpackage

`default_nettype wire

@@ design/bshs_cell.sv @@
// one window position: compares the incoming byte and extends the partial match counts
`default_nettype none

module bshs_cell (
    input  wire logic                           clk,
    input  wire logic                           advance,
    input  wire logic [bshs_pkg::BYTE_W-1:0]    data_in,
    input  wire bshs_pkg::sig_bytes_t           sig_bytes,
    input  wire logic [bshs_pkg::NUM_SIG-1:0]   sig_used,
    input  wire bshs_pkg::counts_t              count_in,
    output bshs_pkg::counts_t                   count_next,
    output bshs_pkg::counts_t                   count_out
);
    import bshs_pkg::*;

    counts_t count_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_SIG; p++)
        begin
            count_next[p] = count_in[p]
                + CNT_W'(sig_used[p] && (data_in == sig_bytes[p]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_reg <= count_next;
        end
    end

    assign count_out = count_reg;

endmodule

`default_nettype wire

@@ design/bshs_chain.sv @@
// row of window cells; each cell hands its partial counts to the next one
`default_nettype none

module bshs_chain (
    input  wire logic                        clk,
    input  wire logic                        advance,
    input  wire logic [bshs_pkg::BYTE_W-1:0] data_in,
    output bshs_pkg::counts_t                tail_next
);
    import bshs_pkg::*;

    counts_t link [WINDOW_LEN+1];
    counts_t nxt  [WINDOW_LEN];

    assign link[0] = '0;

    for (genvar k = 0; k < WINDOW_LEN; k++)
    begin : g_cell
        bshs_cell u_cell (
            .clk        (clk),
            .advance    (advance),
            .data_in    (data_in),
            .sig_bytes  (cell_bytes(CELL_IDX_W'(k))),
            .sig_used   (cell_used(CELL_IDX_W'(k))),
            .count_in   (link[k]),
            .count_next (nxt[k]),
            .count_out  (link[k+1])
        );
    end

    // full counts for the start that lies a window length back
    assign tail_next = nxt[WINDOW_LEN-1];

endmodule

`default_nettype wire

@@ design/byte_signature_hamming_scan.sv @@
// byte signature scanner: takes one byte per cycle, reports the first hit at the end of file
// throughput: one byte per cycle; after the last byte of a file a flush follows
// during which no byte is taken
// the verdict is valid once the last byte is taken and the flush of the 36-cell match chain
// with zero bytes has ended; the flush ends later while an earlier verdict still waits
// reset: asynchronous, active low; thresholds return to 20, 27, 31, 31, file state clears
`default_nettype none

module byte_signature_hamming_scan (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bshs_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  wire logic                               s_tlast,   // last_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [bshs_pkg::M_TDATA_W-1:0]          m_tdata,   // [2:0] verdict, [34:3] match_offset
    input  wire logic                               cfg_we,
    input  wire logic [bshs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bshs_pkg::THR_W-1:0]         cfg_data
);
    import bshs_pkg::*;

    `include "byte_signature_hamming_scan_defines.svh"

    thr_t                       thr_reg [NUM_SIG];
    logic [OFFSET_BITS-1:0]     seen_reg, seen_next, seen_inc;
    logic                       hit_reg, hit_next;
    logic [VERDICT_W-1:0]       code_reg, code_next;
    logic [MATCH_W-1:0]         start_reg, start_next;
    logic                       flush_reg, flush_next;
    logic [FLUSH_CNT_W-1:0]     flush_cnt_reg, flush_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [VERDICT_W-1:0]       m_verdict_reg, m_verdict_next;
    logic [MATCH_W-1:0]         m_offset_reg, m_offset_next;

    logic                       in_take, out_free, flush_step, end_step, advance;
    logic [BYTE_W-1:0]          chain_data;
    counts_t                    counts;
    logic [OFFSET_BITS:0]       size_eval;
    logic                       tried;
    logic                       sig_hit;
    logic [1:0]                 sig_idx;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[SIG_ONE]   <= THR_ONE_RST;
            thr_reg[SIG_TWO]   <= THR_TWO_RST;
            thr_reg[SIG_THREE] <= THR_THREE_RST;
            thr_reg[SIG_FOUR]  <= THR_FOUR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THR_ONE:   thr_reg[SIG_ONE]   <= {1'b0, cfg_data[THR_W-2:0]};
                CFG_THR_TWO:   thr_reg[SIG_TWO]   <= cfg_data;
                CFG_THR_THREE: thr_reg[SIG_THREE] <= cfg_data;
                CFG_THR_FOUR:  thr_reg[SIG_FOUR]  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------- match chain ----------------
    assign s_tready   = !flush_reg;
    assign in_take    = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign flush_step = flush_reg && ((flush_cnt_reg != FLUSH_CNT_W'(FLUSH_LEN)) || out_free);
    assign end_step   = flush_step && (flush_cnt_reg == FLUSH_CNT_W'(FLUSH_LEN));
    assign advance    = in_take || flush_step;
    // bytes past the end of file read as zero
    assign chain_data = flush_reg ? '0 : s_tdata[BYTE_W-1:0];

    bshs_chain u_chain (
        .clk       (clk),
        .advance   (advance),
        .data_in   (chain_data),
        .tail_next (counts)
    );

    // ---------------- start bookkeeping ----------------
    assign seen_inc  = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign size_eval = flush_reg ? ({1'b0, seen_reg} + (OFFSET_BITS+1)'(flush_cnt_reg))
                                 : {1'b0, seen_inc};
    assign tried     = size_eval >= (OFFSET_BITS+1)'(WINDOW_LEN);

    // lowest signature wins among those reaching threshold
    always_comb
    begin
        sig_hit = 1'b0;
        sig_idx = SIG_ONE;
        for (int p = NUM_SIG - 1; p >= 0; p--)
        begin
            if (counts[p] >= thr_reg[p])
            begin
                sig_hit = 1'b1;
                sig_idx = 2'(p);
            end
        end
    end

    always_comb
    begin
        seen_next      = seen_reg;
        hit_next       = hit_reg;
        code_next      = code_reg;
        start_next     = start_reg;
        flush_next     = flush_reg;
        flush_cnt_next = flush_cnt_reg;
        m_valid_next   = m_valid_reg;
        m_verdict_next = m_verdict_reg;
        m_offset_next  = m_offset_reg;

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (in_take)
        begin
            seen_next = seen_inc;
            if (s_tlast)
            begin
                flush_next     = 1'b1;
                flush_cnt_next = FLUSH_CNT_W'(1);
            end
        end

        if (advance && tried && !hit_reg && sig_hit)
        begin
            hit_next   = 1'b1;
            code_next  = VERDICT_W'(sig_idx) + VERDICT_W'(1);
            start_next = MATCH_W'(size_eval - (OFFSET_BITS+1)'(WINDOW_LEN));
        end

        if (flush_step)
        begin
            flush_cnt_next = flush_cnt_reg + 1'b1;
        end

        if (end_step)
        begin
            m_valid_next   = 1'b1;
            m_verdict_next = hit_next ? code_next : VERDICT_CLEAN;
            m_offset_next  = hit_next ? start_next : '0;
            flush_next     = 1'b0;
            seen_next      = '0;
            hit_next       = 1'b0;
            code_next      = VERDICT_CLEAN;
            start_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            hit_reg       <= 1'b0;
            code_reg      <= VERDICT_CLEAN;
            start_reg     <= '0;
            flush_reg     <= 1'b0;
            flush_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            hit_reg       <= hit_next;
            code_reg      <= code_next;
            start_reg     <= start_next;
            flush_reg     <= flush_next;
            flush_cnt_reg <= flush_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_verdict_reg <= m_verdict_next;
        m_offset_reg  <= m_offset_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_offset_reg, m_verdict_reg};

    // ---------------- checks ----------------
    `BSHS_ASSERT_NEXT(a_last_starts_flush, in_take && s_tlast,
        flush_reg && (flush_cnt_reg == FLUSH_CNT_W'(1)), "last byte did not start the flush")
    `BSHS_ASSERT_NEXT(a_end_clears_file, end_step,
        m_valid_reg && !flush_reg && !hit_reg && (seen_reg == '0),
        "file end did not post a verdict and clear the file state")
    `BSHS_ASSERT_NOW(a_clean_has_no_offset, m_valid_reg && (m_verdict_reg == VERDICT_CLEAN),
        m_offset_reg == '0, "clean verdict carries a nonzero offset")

endmodule

`default_nettype wire
